### hdl/tpt_pkg.sv
// Shared types, constants and codes for the taint propagation tracker.
package tpt_pkg;

    localparam int NUM_REGS_DEF      = 25;
    localparam int STORE_ENTRIES_DEF = 64;
    localparam int MASK_W            = 25;
    localparam int ADDR_W            = 32;
    localparam int USED_W            = 7;

    typedef enum logic [2:0] {
        CMD_ARITH     = 3'd0,
        CMD_PUSH_MEM  = 3'd1,
        CMD_STORE_MOV = 3'd2,
        CMD_PUSH_REG  = 3'd3,
        CMD_REG_WRITE = 3'd4,
        CMD_POP       = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        TAG_CLEAN = 2'd0,
        TAG_OVF   = 2'd1,
        TAG_PROP  = 2'd2
    } tag_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic clr_step;
        logic capture;
        logic scan_step;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic idx_last;
        logic out_busy;
    } dp_status_t;

endpackage

### hdl/tpt_ctrl.sv
// Controller state machine: clearing pass, store scan and result hand-off.
module tpt_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  tpt_pkg::dp_status_t status,
    output tpt_pkg::ctrl_cmd_t  ctrl
);
    import tpt_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                ctrl.clr_step = 1'b1;
                if (status.idx_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    ctrl.capture = 1'b1;
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                ctrl.scan_step = 1'b1;
                if (status.idx_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!status.out_busy)
                begin
                    ctrl.finish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

### hdl/tpt_dpath.sv
// Datapath: register tags, address store memory, scan compare and result register.
module tpt_dpath
#(
    parameter int NUM_REGS      = tpt_pkg::NUM_REGS_DEF,
    parameter int STORE_ENTRIES = tpt_pkg::STORE_ENTRIES_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  tpt_pkg::ctrl_cmd_t           ctrl,
    output tpt_pkg::dp_status_t          status,
    input  logic [2:0]                  command,
    input  logic [4:0]                  src_reg,
    input  logic [4:0]                  dest_reg,
    input  logic [tpt_pkg::MASK_W-1:0]  read_reg_mask,
    input  logic [tpt_pkg::ADDR_W-1:0]  read_addr,
    input  logic                        read_addr_valid,
    input  logic [tpt_pkg::ADDR_W-1:0]  write_addr,
    input  logic                        overflow,
    input  logic                        overflow_counts,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  dest_taint,
    output logic                        mem_hit,
    output logic                        new_taint,
    output logic                        store_full_drop,
    output logic [tpt_pkg::USED_W-1:0]  entries_used
);
    import tpt_pkg::*;

    localparam int IDX_W  = (STORE_ENTRIES > 1) ? $clog2(STORE_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(STORE_ENTRIES + 1);
    localparam int MLIM   = (NUM_REGS < MASK_W) ? NUM_REGS : MASK_W;

    // Captured transaction.
    logic [2:0]        cmd_reg;
    logic [4:0]        src_sel_reg;
    logic [4:0]        dst_sel_reg;
    logic [MASK_W-1:0] mask_reg;
    logic [ADDR_W-1:0] raddr_reg;
    logic              rvalid_reg;
    logic [ADDR_W-1:0] waddr_reg;
    logic              ov_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            cmd_reg     <= command;
            src_sel_reg <= src_reg;
            dst_sel_reg <= dest_reg;
            mask_reg    <= read_reg_mask;
            raddr_reg   <= read_addr;
            rvalid_reg  <= read_addr_valid;
            waddr_reg   <= write_addr;
            ov_reg      <= overflow & overflow_counts;
        end
    end

    // Address store: valid bit on top of each word.
    logic [ADDR_W:0]   mem [STORE_ENTRIES];
    logic [ADDR_W:0]   rd_data_reg;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [ADDR_W:0]   mem_wdata;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic              rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[idx_reg];
        rd_idx_reg  <= idx_reg;
    end

    assign status.idx_last = (idx_reg == IDX_W'(STORE_ENTRIES - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= ctrl.scan_step;
            if (ctrl.clr_step || ctrl.scan_step)
            begin
                idx_reg <= status.idx_last ? '0 : idx_reg + IDX_W'(1);
            end
        end
    end

    // Scan results, one store word compared per cycle.
    logic             hit_r_reg;
    logic             wfound_reg;
    logic [IDX_W-1:0] widx_reg;
    logic             free_found_reg;
    logic [IDX_W-1:0] free_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_r_reg      <= 1'b0;
            wfound_reg     <= 1'b0;
            free_found_reg <= 1'b0;
            widx_reg       <= '0;
            free_idx_reg   <= '0;
        end
        else if (ctrl.capture)
        begin
            hit_r_reg      <= 1'b0;
            wfound_reg     <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else if (rd_vld_reg)
        begin
            if (rd_data_reg[ADDR_W] && rd_data_reg[ADDR_W-1:0] == raddr_reg)
            begin
                hit_r_reg <= 1'b1;
            end
            if (rd_data_reg[ADDR_W] && rd_data_reg[ADDR_W-1:0] == waddr_reg)
            begin
                wfound_reg <= 1'b1;
                widx_reg   <= rd_idx_reg;
            end
            if (!rd_data_reg[ADDR_W] && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= rd_idx_reg;
            end
        end
    end

    // Register tags; register 0 is never written and stays clean.
    logic [1:0] tags_reg [NUM_REGS];
    logic [1:0] src_tag;
    logic       mask_tainted;

    always_comb
    begin
        src_tag      = TAG_CLEAN;
        mask_tainted = 1'b0;
        for (int i = 0; i < NUM_REGS; i++)
        begin
            if (7'(src_sel_reg) == 7'(i))
            begin
                src_tag = tags_reg[i];
            end
        end
        for (int i = 0; i < MLIM; i++)
        begin
            if (mask_reg[i] && tags_reg[i] != TAG_CLEAN)
            begin
                mask_tainted = 1'b1;
            end
        end
    end

    // Rule evaluation at the end of the scan.
    logic       writes_dest;
    logic [1:0] dtag_c;
    logic       hit_c;
    logic       newt_c;
    logic       ins_c;
    logic       ers_c;
    logic       ins_ok;
    logic       ers_ok;
    logic       drop_c;
    logic       dest_ok;

    always_comb
    begin
        writes_dest = 1'b0;
        dtag_c      = TAG_CLEAN;
        hit_c       = 1'b0;
        newt_c      = 1'b0;
        ins_c       = 1'b0;
        ers_c       = 1'b0;
        case (cmd_t'(cmd_reg))
            CMD_ARITH:
            begin
                newt_c = ov_reg;
                ins_c  = ov_reg || (src_tag != TAG_CLEAN);
            end
            CMD_PUSH_MEM:
            begin
                hit_c = hit_r_reg;
                ins_c = hit_r_reg;
                ers_c = !hit_r_reg;
            end
            CMD_STORE_MOV, CMD_PUSH_REG:
            begin
                ins_c = (src_tag != TAG_CLEAN);
                ers_c = (src_tag == TAG_CLEAN);
            end
            CMD_REG_WRITE:
            begin
                writes_dest = 1'b1;
                if (ov_reg)
                begin
                    dtag_c = TAG_OVF;
                    newt_c = 1'b1;
                end
                else
                begin
                    hit_c  = rvalid_reg & hit_r_reg;
                    dtag_c = (mask_tainted || hit_c) ? TAG_PROP : TAG_CLEAN;
                end
            end
            CMD_POP:
            begin
                writes_dest = 1'b1;
                hit_c       = hit_r_reg;
                dtag_c      = hit_r_reg ? TAG_OVF : TAG_CLEAN;
            end
            default:
            begin
                writes_dest = 1'b0;
            end
        endcase
        dest_ok = writes_dest && dst_sel_reg != 5'd0 && 7'(dst_sel_reg) < 7'(NUM_REGS);
        ins_ok  = ins_c && !wfound_reg && free_found_reg;
        drop_c  = ins_c && !wfound_reg && !free_found_reg;
        ers_ok  = ers_c && wfound_reg;
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = '0;
        if (ctrl.clr_step)
        begin
            mem_we = 1'b1;
        end
        else if (ctrl.finish && ins_ok)
        begin
            mem_we    = 1'b1;
            mem_waddr = free_idx_reg;
            mem_wdata = {1'b1, waddr_reg};
        end
        else if (ctrl.finish && ers_ok)
        begin
            mem_we    = 1'b1;
            mem_waddr = widx_reg;
        end
    end

    logic [CNT_W-1:0] used_reg;
    logic [CNT_W-1:0] used_next;

    always_comb
    begin
        used_next = used_reg;
        if (ctrl.finish && ins_ok)
        begin
            used_next = used_reg + CNT_W'(1);
        end
        else if (ctrl.finish && ers_ok)
        begin
            used_next = used_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            for (int i = 0; i < NUM_REGS; i++)
            begin
                tags_reg[i] <= TAG_CLEAN;
            end
        end
        else
        begin
            used_reg <= used_next;
            if (ctrl.finish && dest_ok)
            begin
                for (int i = 1; i < NUM_REGS; i++)
                begin
                    if (7'(dst_sel_reg) == 7'(i))
                    begin
                        tags_reg[i] <= dtag_c;
                    end
                end
            end
        end
    end

    // Result register: a finished transaction waits here while the next is taken in.
    logic out_full_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_full_reg <= 1'b0;
        end
        else if (ctrl.finish)
        begin
            out_full_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.finish)
        begin
            dest_taint      <= dest_ok ? dtag_c : TAG_CLEAN;
            mem_hit         <= hit_c;
            new_taint       <= newt_c;
            store_full_drop <= drop_c;
            entries_used    <= USED_W'(used_next);
        end
    end

    assign out_valid       = out_full_reg;
    assign status.out_busy = out_full_reg & out_stall;

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_W'(STORE_ENTRIES))
        else $error("store occupancy count above capacity");

    a_reg0_clean: assert property (@(posedge clk) disable iff (!rst_n)
        tags_reg[0] == TAG_CLEAN)
        else $error("register 0 carries a taint tag");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.finish && drop_c |-> used_reg == CNT_W'(STORE_ENTRIES))
        else $error("insert dropped while store has room");

    a_finish_lands: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.finish |=> out_valid)
        else $error("finished transaction not presented");

endmodule

### hdl/taint_propagation_tracker.sv
// Top level of the taint propagation tracker: controller plus datapath.
//
// Input channel: one retired-instruction transaction (command, registers,
// addresses, overflow flags) is taken when in_valid is high and in_stall is
// low. Output channel: one result transaction per input (dest_taint, mem_hit,
// new_taint, store_full_drop, entries_used), taken when out_valid is high and
// out_stall is low.
// The address store is a memory with one registered read port, searched one
// entry per cycle: the scan reads every entry, a drain state waits for the
// last registered read, and a finish state applies the rule and loads the
// result register. A new transaction is accepted only once the previous one
// has finished and the controller is back in its idle state.
// After reset the block runs a clearing pass that invalidates every store
// entry; in_stall is high during it. Register tags and the occupancy count
// clear at once.
// A result held by out_stall sits in the output register while the next
// transaction is accepted and scanned; only the rule update waits for it.
module taint_propagation_tracker
#(
    parameter int NUM_REGS      = tpt_pkg::NUM_REGS_DEF,
    parameter int STORE_ENTRIES = tpt_pkg::STORE_ENTRIES_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [2:0]                  command,
    input  logic [4:0]                  src_reg,
    input  logic [4:0]                  dest_reg,
    input  logic [tpt_pkg::MASK_W-1:0]  read_reg_mask,
    input  logic [tpt_pkg::ADDR_W-1:0]  read_addr,
    input  logic                        read_addr_valid,
    input  logic [tpt_pkg::ADDR_W-1:0]  write_addr,
    input  logic                        overflow,
    input  logic                        overflow_counts,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  dest_taint,
    output logic                        mem_hit,
    output logic                        new_taint,
    output logic                        store_full_drop,
    output logic [tpt_pkg::USED_W-1:0]  entries_used
);
    import tpt_pkg::*;

    ctrl_cmd_t  ctrl;
    dp_status_t status;

    tpt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .ctrl     (ctrl)
    );

    tpt_dpath
    #(
        .NUM_REGS      (NUM_REGS),
        .STORE_ENTRIES (STORE_ENTRIES)
    )
    u_dpath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctrl            (ctrl),
        .status          (status),
        .command         (command),
        .src_reg         (src_reg),
        .dest_reg        (dest_reg),
        .read_reg_mask   (read_reg_mask),
        .read_addr       (read_addr),
        .read_addr_valid (read_addr_valid),
        .write_addr      (write_addr),
        .overflow        (overflow),
        .overflow_counts (overflow_counts),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .dest_taint      (dest_taint),
        .mem_hit         (mem_hit),
        .new_taint       (new_taint),
        .store_full_drop (store_full_drop),
        .entries_used    (entries_used)
    );

endmodule
